// File: design/byte_ring_fifo_with_peek_defines.svh
// Assertion macros for the circular byte FIFO top-level design file.
`ifndef BYTE_RING_FIFO_WITH_PEEK_DEFINES_SVH
`define BYTE_RING_FIFO_WITH_PEEK_DEFINES_SVH

`ifndef SYNTH
// Clocked check that is switched off while reset is asserted.
`define BRF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("byte ring FIFO assertion failed");
// Clocked check that stays active through reset.
`define BRF_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("byte ring FIFO reset assertion failed");
`else
`define BRF_ASSERT(lbl, prop)
`define BRF_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// File: design/brf_pkg.sv
// Package with the sizes and command codes of the circular byte FIFO.
`default_nettype none

package brf_pkg;

  // Number of entries in the byte store.
  localparam int DEPTH = 64;
  // Pointer width into the byte store.
  localparam int PTR_W = $clog2(DEPTH);
  // Width of counts, capacity and fill level.
  localparam int CNT_W = 7;
  // Width of one stored byte.
  localparam int DATA_W = 8;
  // Width of the command field.
  localparam int CMD_W = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT     = 3'd0,
    CMD_GET     = 3'd1,
    CMD_PEEK    = 3'd2,
    CMD_FLUSH   = 3'd3,
    CMD_DISCARD = 3'd4
  } cmd_t;

endpackage

`default_nettype wire

// File: design/byte_ring_fifo_with_peek.sv
// Top level of the circular byte FIFO with peek, discard and flush.
// Put, flush, discard, unknown commands and empty get or peek give one result in the
//   cycle after acceptance. A get or peek of n bytes passes the run state, the registered
//   read of the single RAM read port and the output register, then gives one byte per
//   cycle; when idle it takes a single-result command per cycle. Runs hold busy through
//   their reads and the drain state. Reset (rst_n low, synchronous) empties the FIFO and
//   sets capacity 64; the receiver cannot stall, so each result shows for one cycle only.
`default_nettype none

module byte_ring_fifo_with_peek (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // Command channel.
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [brf_pkg::CMD_W-1:0]  in_command,
  input  wire logic [brf_pkg::DATA_W-1:0] in_data_byte,
  input  wire logic [brf_pkg::CNT_W-1:0]  in_count,
  // Result channel.
  output logic                           out_strobe,
  output logic      [brf_pkg::DATA_W-1:0] out_data_byte_out,
  output logic                           out_byte_valid,
  output logic                           out_last,
  output logic      [brf_pkg::CNT_W-1:0]  out_transferred,
  output logic                           out_accepted,
  output logic      [brf_pkg::CNT_W-1:0]  out_bytes_used,
  // Capacity register.
  input  wire logic                      cfg_we,
  input  wire logic [brf_pkg::CNT_W-1:0]  cfg_wdata
);

  `include "byte_ring_fifo_with_peek_defines.svh"

  // The sequencer is idle, streams reads for a get or peek run, or waits in the drain
  // state for the read data of the final byte of the run.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  state_t state_r, state_nxt;

  // FIFO bookkeeping. The capacity register always holds a value from 1 to DEPTH,
  // and both pointers always stay below it, because a capacity write empties the FIFO.
  logic [brf_pkg::PTR_W-1:0] rp_r, rp_nxt;
  logic [brf_pkg::PTR_W-1:0] wp_r, wp_nxt;
  logic [brf_pkg::CNT_W-1:0] fill_r, fill_nxt;
  logic [brf_pkg::CNT_W-1:0] cap_r, cap_nxt;

  // Run state: the read pointer of the run, the reads still to issue, the run length,
  // and a flag for the read that was issued last cycle (its data arrives now).
  logic [brf_pkg::PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [brf_pkg::CNT_W-1:0] left_r, left_nxt;
  logic [brf_pkg::CNT_W-1:0] run_n_r, run_n_nxt;
  logic                      pend_r, pend_nxt;
  logic                      pend_last_r, pend_last_nxt;

  // Output registers.
  logic                      strobe_r, strobe_nxt;
  logic [brf_pkg::DATA_W-1:0] odata_r, odata_nxt;
  logic                      ovalid_r, ovalid_nxt;
  logic                      olast_r, olast_nxt;
  logic [brf_pkg::CNT_W-1:0] oxfer_r, oxfer_nxt;
  logic                      oacc_r, oacc_nxt;
  logic [brf_pkg::CNT_W-1:0] oused_r, oused_nxt;

  // Byte store interface.
  logic                      ram_we;
  logic                      ram_re;
  logic [brf_pkg::DATA_W-1:0] ram_rdata;

  // Datapath helpers.
  logic [brf_pkg::CNT_W-1:0] n_clip;
  logic [brf_pkg::CNT_W:0]   rp_sum;
  logic [brf_pkg::CNT_W:0]   rp_wrap;
  logic [brf_pkg::CNT_W-1:0] wp_inc;
  logic [brf_pkg::CNT_W-1:0] rd_inc;
  logic [brf_pkg::CNT_W-1:0] cap_norm;

  // A get, peek or discard is clipped to the bytes held.
  assign n_clip = (in_count < fill_r) ? in_count : fill_r;

  // Read pointer after removing n bytes. The pointer is below the capacity and n is
  // at most the capacity, so one conditional subtract wraps the sum.
  assign rp_sum  = {{(brf_pkg::CNT_W + 1 - brf_pkg::PTR_W){1'b0}}, rp_r}
                 + {1'b0, n_clip};
  assign rp_wrap = (rp_sum >= {1'b0, cap_r}) ? (rp_sum - {1'b0, cap_r}) : rp_sum;

  // Single-step increments, compared against the capacity for the wrap.
  assign wp_inc = {{(brf_pkg::CNT_W - brf_pkg::PTR_W){1'b0}}, wp_r} + 1'b1;
  assign rd_inc = {{(brf_pkg::CNT_W - brf_pkg::PTR_W){1'b0}}, rd_ptr_r} + 1'b1;

  // A capacity of zero acts as one slot, and anything above the store depth as the depth.
  always_comb begin
    if (cfg_wdata == '0) begin
      cap_norm = {{(brf_pkg::CNT_W - 1){1'b0}}, 1'b1};
    end else if (cfg_wdata > brf_pkg::CNT_W'(brf_pkg::DEPTH)) begin
      cap_norm = brf_pkg::CNT_W'(brf_pkg::DEPTH);
    end else begin
      cap_norm = cfg_wdata;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    rp_nxt        = rp_r;
    wp_nxt        = wp_r;
    fill_nxt      = fill_r;
    cap_nxt       = cap_r;
    rd_ptr_nxt    = rd_ptr_r;
    left_nxt      = left_r;
    run_n_nxt     = run_n_r;
    pend_nxt      = 1'b0;
    pend_last_nxt = 1'b0;
    strobe_nxt    = 1'b0;
    odata_nxt     = odata_r;
    ovalid_nxt    = ovalid_r;
    olast_nxt     = olast_r;
    oxfer_nxt     = oxfer_r;
    oacc_nxt      = oacc_r;
    oused_nxt     = oused_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;

    // Read data of the previous cycle's read becomes one byte transaction of the run.
    // The fill level was already updated when the command was taken.
    if (pend_r) begin
      strobe_nxt = 1'b1;
      odata_nxt  = ram_rdata;
      ovalid_nxt = 1'b1;
      olast_nxt  = pend_last_r;
      oxfer_nxt  = run_n_r;
      oacc_nxt   = 1'b0;
      oused_nxt  = fill_r;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          // Defaults for a single-result command; the arms below adjust them.
          strobe_nxt = 1'b1;
          odata_nxt  = '0;
          ovalid_nxt = 1'b0;
          olast_nxt  = 1'b1;
          oxfer_nxt  = '0;
          oacc_nxt   = 1'b0;
          oused_nxt  = fill_r;
          unique case (in_command) inside
            brf_pkg::CMD_PUT: begin
              if (fill_r < cap_r) begin
                ram_we    = 1'b1;
                wp_nxt    = (wp_inc >= cap_r) ? '0 : wp_inc[brf_pkg::PTR_W-1:0];
                fill_nxt  = fill_r + 1'b1;
                oxfer_nxt = {{(brf_pkg::CNT_W - 1){1'b0}}, 1'b1};
                oacc_nxt  = 1'b1;
                oused_nxt = fill_r + 1'b1;
              end
            end
            brf_pkg::CMD_GET, brf_pkg::CMD_PEEK: begin
              if (in_command == brf_pkg::CMD_GET) begin
                rp_nxt    = rp_wrap[brf_pkg::PTR_W-1:0];
                fill_nxt  = fill_r - n_clip;
              end
              if (n_clip != '0) begin
                // Hand the run to the read sequencer; it emits every transaction.
                strobe_nxt = 1'b0;
                state_nxt  = ST_RUN;
                rd_ptr_nxt = rp_r;
                left_nxt   = n_clip;
                run_n_nxt  = n_clip;
              end
            end
            brf_pkg::CMD_DISCARD: begin
              rp_nxt    = rp_wrap[brf_pkg::PTR_W-1:0];
              fill_nxt  = fill_r - n_clip;
              oxfer_nxt = n_clip;
              oused_nxt = fill_r - n_clip;
            end
            brf_pkg::CMD_FLUSH: begin
              rp_nxt    = '0;
              wp_nxt    = '0;
              fill_nxt  = '0;
              oused_nxt = '0;
            end
            default: begin
              // Unused command codes leave the FIFO as it is.
            end
          endcase
        end
      end
      ST_RUN: begin
        ram_re        = 1'b1;
        pend_nxt      = 1'b1;
        pend_last_nxt = (left_r == {{(brf_pkg::CNT_W - 1){1'b0}}, 1'b1});
        rd_ptr_nxt    = (rd_inc >= cap_r) ? '0 : rd_inc[brf_pkg::PTR_W-1:0];
        left_nxt      = left_r - 1'b1;
        if (pend_last_nxt) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Capacity write empties the FIFO; issue it only while the block is idle (unchecked).
    if (cfg_we) begin
      cap_nxt  = cap_norm;
      rp_nxt   = '0;
      wp_nxt   = '0;
      fill_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rp_r        <= '0;
      wp_r        <= '0;
      fill_r      <= '0;
      cap_r       <= brf_pkg::CNT_W'(brf_pkg::DEPTH);
      pend_r      <= 1'b0;
      pend_last_r <= 1'b0;
      strobe_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rp_r        <= rp_nxt;
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      cap_r       <= cap_nxt;
      pend_r      <= pend_nxt;
      pend_last_r <= pend_last_nxt;
      strobe_r    <= strobe_nxt;
    end
    rd_ptr_r <= rd_ptr_nxt;
    left_r   <= left_nxt;
    run_n_r  <= run_n_nxt;
    odata_r  <= odata_nxt;
    ovalid_r <= ovalid_nxt;
    olast_r  <= olast_nxt;
    oxfer_r  <= oxfer_nxt;
    oacc_r   <= oacc_nxt;
    oused_r  <= oused_nxt;
  end

  // The byte store. Writes happen only when idle and reads only during a run, so
  // the busy interlock keeps a write and a read of the same entry from overlapping.
  brf_ram #(
    .W (brf_pkg::DATA_W),
    .D (brf_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (in_data_byte),
    .re    (ram_re),
    .raddr (rd_ptr_r),
    .rdata (ram_rdata)
  );

  assign busy              = (state_r != ST_IDLE);
  assign out_strobe        = strobe_r;
  assign out_data_byte_out = odata_r;
  assign out_byte_valid    = ovalid_r;
  assign out_last          = olast_r;
  assign out_transferred   = oxfer_r;
  assign out_accepted      = oacc_r;
  assign out_bytes_used    = oused_r;

  // The fill level never exceeds the configured capacity.
  `BRF_ASSERT(a_fill_le_cap, fill_r <= cap_r)
  // While reads are issued, at least one read is still owed.
  `BRF_ASSERT(a_run_left_nonzero, (state_r == ST_RUN) |-> (left_r != '0))
  // Leaving the drain state, the final byte of the run is on the result ports.
  `BRF_ASSERT(a_drain_gives_last, (state_r == ST_DRAIN) |=> (out_strobe && out_last))
  // No result transaction appears right after reset.
  `BRF_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_strobe)

endmodule

`default_nettype wire

// File: design/brf_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module brf_ram #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic                 re,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: tb/sv/byte_ring_fifo_with_peek_tb.sv
// Self-checking testbench for the circular byte FIFO with peek, discard and flush.
`timescale 1ns / 1ps

module byte_ring_fifo_with_peek_tb;
  import brf_pkg::*;

  // Command codes that the block does not define. They must be answered with a
  // single empty result and must leave the FIFO untouched.
  localparam logic [CMD_W-1:0] CMD_RESERVED_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RESERVED_LAST  = 3'd7;

  // The slowest legal run is about 125 commands, plus random gaps and settling.
  // This bound is many times that.
  localparam int LIMIT_CYCLES = 200000;
  // Cycles to wait after the last expected result before touching the capacity
  // register or ending the run.
  localparam int SETTLE_CYCLES = 6;

  // One result transaction, at the widths of the result ports.
  typedef struct packed {
    logic [DATA_W-1:0] data_byte_out;
    logic              byte_valid;
    logic              last;
    logic [CNT_W-1:0]  transferred;
    logic              accepted;
    logic [CNT_W-1:0]  bytes_used;
  } fifo_result_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [CMD_W-1:0]    in_command;
  logic [DATA_W-1:0]   in_data_byte;
  logic [CNT_W-1:0]    in_count;
  logic                out_strobe;
  logic [DATA_W-1:0]   out_data_byte_out;
  logic                out_byte_valid;
  logic                out_last;
  logic [CNT_W-1:0]    out_transferred;
  logic                out_accepted;
  logic [CNT_W-1:0]    out_bytes_used;
  logic                cfg_we;
  logic [CNT_W-1:0]    cfg_wdata;

  // Shadow copy of the FIFO that predicts every result the block should emit.
  logic [DATA_W-1:0]   shadow_bytes [DEPTH];
  int                  shadow_rd;
  int                  shadow_wr;
  int                  shadow_fill;
  logic [CNT_W-1:0]    shadow_capacity;

  // Results predicted but not yet seen on the result ports, oldest first.
  fifo_result_t        pending_results[$];

  int                  error_count;
  int                  commands_sent;
  int                  results_checked;
  int                  capacity_writes;
  int                  longest_run;
  int                  cycle_count;

  byte_ring_fifo_with_peek DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_command        (in_command),
    .in_data_byte      (in_data_byte),
    .in_count          (in_count),
    .out_strobe        (out_strobe),
    .out_data_byte_out (out_data_byte_out),
    .out_byte_valid    (out_byte_valid),
    .out_last          (out_last),
    .out_transferred   (out_transferred),
    .out_accepted      (out_accepted),
    .out_bytes_used    (out_bytes_used),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  // 8 ns clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run as a failure.
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding.",
             cycle_count, pending_results.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Every mismatch goes through here: one line and one count.
  task automatic report_mismatch(input string msg);
    $display("[%0t] ERROR: %s", $time, msg);
    error_count++;
  endtask

  // Number of slots the capacity register really selects. Zero behaves as one
  // slot and anything above the store depth behaves as the full store.
  function automatic int slots_in_use();
    if (shadow_capacity == '0) return 1;
    if (int'(shadow_capacity) > DEPTH) return DEPTH;
    return int'(shadow_capacity);
  endfunction

  // Queue one expected result. Every result reports the fill level after the
  // command, so the caller updates the shadow state first.
  function automatic void push_result(input logic [DATA_W-1:0] data, input logic valid,
                                      input logic last, input int xfer, input logic acc);
    fifo_result_t r;
    r.data_byte_out = data;
    r.byte_valid    = valid;
    r.last          = last;
    r.transferred   = CNT_W'(xfer);
    r.accepted      = acc;
    r.bytes_used    = CNT_W'(shadow_fill);
    pending_results.push_back(r);
  endfunction

  // Apply one accepted command to the shadow FIFO and queue what it must produce.
  function automatic void predict_command(input logic [CMD_W-1:0] cmd,
                                          input logic [DATA_W-1:0] din,
                                          input logic [CNT_W-1:0] cnt);
    int cap;
    int n;
    int p;
    cap = slots_in_use();
    // Pointers are kept inside the active slots; the capacity write already
    // empties the FIFO, so these only guard against a stale state.
    if (shadow_rd >= cap) shadow_rd = 0;
    if (shadow_wr >= cap) shadow_wr = 0;
    if (shadow_fill > cap) shadow_fill = cap;
    case (cmd)
      CMD_PUT: begin
        if (shadow_fill < cap) begin
          shadow_bytes[PTR_W'(shadow_wr)] = din;
          shadow_wr = (shadow_wr + 1 >= cap) ? 0 : shadow_wr + 1;
          shadow_fill++;
          push_result('0, 1'b0, 1'b1, 1, 1'b1);
        end else begin
          // Full: the byte is dropped and the put reports nothing transferred.
          push_result('0, 1'b0, 1'b1, 0, 1'b0);
        end
      end
      CMD_GET, CMD_PEEK, CMD_DISCARD: begin
        // The request is clipped to the bytes held.
        n = (int'(cnt) < shadow_fill) ? int'(cnt) : shadow_fill;
        p = shadow_rd;
        if (cmd != CMD_PEEK) begin
          shadow_rd = (shadow_rd + n) % cap;
          shadow_fill -= n;
        end
        if (cmd == CMD_DISCARD || n == 0) begin
          push_result('0, 1'b0, 1'b1, n, 1'b0);
        end else begin
          for (int i = 0; i < n; i++) begin
            push_result(shadow_bytes[PTR_W'(p)], 1'b1, (i == n - 1), n, 1'b0);
            p = (p + 1 >= cap) ? 0 : p + 1;
          end
          if (n > longest_run) longest_run = n;
        end
      end
      CMD_FLUSH: begin
        shadow_rd = 0;
        shadow_wr = 0;
        shadow_fill = 0;
        push_result('0, 1'b0, 1'b1, 0, 1'b0);
      end
      default: begin
        push_result('0, 1'b0, 1'b1, 0, 1'b0);
      end
    endcase
  endfunction

  task automatic check_field(input string field, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("result %0d field %s: got %0d, expected %0d",
                                results_checked, field, got, want));
  endtask

  // Result checker. The receiver cannot hold results off, so every cycle with
  // the strobe high is one result transaction. Sampling at the rising edge sees
  // the values that the block held through the cycle that just ended.
  always @(posedge clk) begin
    fifo_result_t want;
    if (rst_n === 1'b1 && out_strobe === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result: byte %0d valid %0b last %0b used %0d",
                                  out_data_byte_out, out_byte_valid, out_last,
                                  out_bytes_used));
      end else begin
        want = pending_results.pop_front();
        check_field("data_byte_out", int'(out_data_byte_out), int'(want.data_byte_out));
        check_field("byte_valid", int'(out_byte_valid), int'(want.byte_valid));
        check_field("last", int'(out_last), int'(want.last));
        check_field("transferred", int'(out_transferred), int'(want.transferred));
        check_field("accepted", int'(out_accepted), int'(want.accepted));
        check_field("bytes_used", int'(out_bytes_used), int'(want.bytes_used));
        results_checked++;
      end
    end
  end

  // Send one command. Fields change at the falling edge and the transaction
  // completes at the first rising edge with busy low. Start is left high on
  // return so that a following command can go out back to back; whoever does
  // something else next lowers it at the next falling edge.
  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] din,
                              input logic [CNT_W-1:0] cnt);
    @(negedge clk);
    start        <= 1'b1;
    in_command   <= cmd;
    in_data_byte <= din;
    in_count     <= cnt;
    do @(posedge clk); while (busy !== 1'b0);
    predict_command(cmd, din, cnt);
    commands_sent++;
  endtask

  // Idle with start low and random junk on the command fields,
  // which the block must ignore.
  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      start        <= 1'b0;
      in_command   <= CMD_W'($urandom);
      in_data_byte <= DATA_W'($urandom);
      in_count     <= CNT_W'($urandom);
    end
  endtask

  // Stop sending, wait for every predicted result, then give the block time to
  // finish anything that would not show up as a result.
  task automatic drain_results();
    idle_cycles(1);
    while (pending_results.size() != 0) @(negedge clk);
    idle_cycles(SETTLE_CYCLES);
  endtask

  // Capacity write. Only done while idle, since it empties the FIFO.
  task automatic write_capacity(input logic [CNT_W-1:0] value);
    drain_results();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    shadow_capacity = value;
    shadow_rd = 0;
    shadow_wr = 0;
    shadow_fill = 0;
    capacity_writes++;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_wdata <= CNT_W'($urandom);
  endtask

  // Right after reset: the FIFO is empty, so reads of any kind come back empty.
  task automatic test_empty_after_reset();
    send_command(CMD_PEEK, 8'h00, 7'd5);
    send_command(CMD_GET, 8'hFF, 7'd0);
    send_command(CMD_DISCARD, 8'h00, 7'd3);
    drain_results();
  endtask

  // Byte extremes in, then a peek far past the bytes held, a zero-length get,
  // a partial get and a discard that is clipped.
  task automatic test_put_peek_get();
    send_command(CMD_PUT, 8'h00, 7'd0);
    send_command(CMD_PUT, 8'hFF, 7'd127);
    send_command(CMD_PUT, 8'hA5, 7'd0);
    send_command(CMD_PEEK, 8'h00, 7'd127);
    send_command(CMD_GET, 8'h00, 7'd0);
    send_command(CMD_GET, 8'h00, 7'd2);
    send_command(CMD_DISCARD, 8'h00, 7'd64);
    drain_results();
  endtask

  // Undefined commands must not disturb the held byte; flush then empties it.
  task automatic test_flush_and_unknown();
    send_command(CMD_PUT, 8'h5A, 7'd0);
    for (int c = CMD_RESERVED_FIRST; c <= CMD_RESERVED_LAST; c++)
      send_command(CMD_W'(c), 8'hFF, 7'd127);
    send_command(CMD_FLUSH, 8'h00, 7'd0);
    send_command(CMD_GET, 8'h00, 7'd1);
    drain_results();
  endtask

  // Capacity zero behaves as one slot: the second put is refused.
  task automatic test_capacity_floor();
    write_capacity(7'd0);
    send_command(CMD_PUT, 8'h11, 7'd0);
    send_command(CMD_PUT, 8'h22, 7'd0);
    send_command(CMD_PEEK, 8'h00, 7'd1);
    send_command(CMD_GET, 8'h00, 7'd1);
    drain_results();
  endtask

  // Three slots: fill past full, drain, and refill so the pointers wrap.
  task automatic test_small_ring_wrap();
    write_capacity(7'd3);
    for (int i = 0; i < 4; i++)
      send_command(CMD_PUT, DATA_W'(8'h30 + i), 7'd0);
    send_command(CMD_GET, 8'h00, 7'd64);
    send_command(CMD_PUT, 8'h41, 7'd0);
    send_command(CMD_PUT, 8'h42, 7'd0);
    send_command(CMD_GET, 8'h00, 7'd127);
    drain_results();
  endtask

  // An over-range capacity selects the whole store. Fill all of it with no gaps,
  // overflow once, then read the whole store out twice: the longest runs.
  task automatic test_full_depth();
    write_capacity(7'd127);
    repeat (DEPTH + 1)
      send_command(CMD_PUT, DATA_W'($urandom), CNT_W'($urandom));
    send_command(CMD_PEEK, 8'h00, 7'd127);
    send_command(CMD_GET, 8'h00, 7'd64);
    send_command(CMD_PUT, DATA_W'($urandom), 7'd0);
    send_command(CMD_DISCARD, 8'h00, 7'd1);
    drain_results();
  endtask

  // Random traffic under one capacity setting. Puts dominate so that small rings
  // run full; read lengths mostly reach just past the capacity, sometimes far above it.
  // The sender goes in bursts with random gaps, which land on every stage of a run.
  task automatic test_random_traffic(input logic [CNT_W-1:0] capacity, input int n_items);
    int pick;
    int cap;
    int burst_left;
    logic [CMD_W-1:0] cmd;
    logic [CNT_W-1:0] cnt;
    write_capacity(capacity);
    cap = slots_in_use();
    burst_left = $urandom_range(1, 10);
    repeat (n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 45)      cmd = CMD_PUT;
      else if (pick < 62) cmd = CMD_GET;
      else if (pick < 78) cmd = CMD_PEEK;
      else if (pick < 88) cmd = CMD_DISCARD;
      else if (pick < 92) cmd = CMD_FLUSH;
      else if (pick < 95) cmd = CMD_W'($urandom_range(CMD_RESERVED_FIRST, CMD_RESERVED_LAST));
      else                cmd = CMD_PUT;
      pick = $urandom_range(0, 99);
      if (pick < 80)      cnt = CNT_W'($urandom_range(0, cap + 2));
      else if (pick < 95) cnt = CNT_W'($urandom_range(cap, DEPTH));
      else                cnt = CNT_W'($urandom_range(DEPTH + 1, 127));
      send_command(cmd, DATA_W'($urandom), cnt);
      burst_left--;
      if (burst_left == 0) begin
        // Now and then the next burst follows with no gap at all.
        if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 6));
        burst_left = $urandom_range(1, 10);
      end
    end
    drain_results();
  endtask

  initial begin
    // Every input has a known value from time zero.
    rst_n        = 1'b0;
    start        = 1'b0;
    in_command   = '0;
    in_data_byte = '0;
    in_count     = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    error_count     = 0;
    commands_sent   = 0;
    results_checked = 0;
    capacity_writes = 0;
    longest_run     = 0;
    // Shadow state after reset: empty FIFO, capacity 64.
    shadow_rd       = 0;
    shadow_wr       = 0;
    shadow_fill     = 0;
    shadow_capacity = 7'd64;
    foreach (shadow_bytes[i]) shadow_bytes[i] = '0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_after_reset();
    test_put_peek_get();
    test_flush_and_unknown();
    test_capacity_floor();
    test_small_ring_wrap();
    test_full_depth();
    test_random_traffic(7'd2, 5);
    test_random_traffic(7'd1, 4);
    test_random_traffic(CNT_W'($urandom_range(4, 12)), 5);
    test_random_traffic(7'd64, 4);
    test_random_traffic(CNT_W'($urandom_range(65, 126)), 4);
    test_random_traffic(CNT_W'($urandom_range(13, 63)), 5);

    $display("Run covered %0d commands and %0d results over %0d capacity settings.",
             commands_sent, results_checked, capacity_writes);
    $display("Longest get or peek run was %0d bytes; %0d mismatches found.",
             longest_run, error_count);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/brf_pkg.sv
design/brf_ram.sv
design/byte_ring_fifo_with_peek.sv
tb/sv/byte_ring_fifo_with_peek_tb.sv
